>>> rtl/ftg_pkg.sv
// ftg_pkg: shared types and constants for the fft twiddle generator.
// No dependencies; imported by every ftg module and the top level.
`default_nettype none

package ftg_pkg;

  localparam int INDEX_W = 11;
  localparam int COEF_W = 16;
  localparam int LOG2_W = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam int MAX_LOG2_SIZE_DEFAULT = 12;
  localparam logic [LOG2_W-1:0] LOG2_SIZE_RESET = 4'd10;

  // number of taylor terms after the leading one
  localparam int N_TERMS = 7;

  // pi in q2.30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LOG2_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERSE = 1'd1;

  // quadrant codes of the phase
  localparam logic [1:0] QUAD_FIRST = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  // one item in flight through the series pipeline
  typedef struct packed {
    logic [29:0] x2;
    logic [30:0] sin_term;
    logic [30:0] cos_term;
    logic [30:0] sin_sum;
    logic [30:0] cos_sum;
    logic        swap;
    logic [1:0]  quad;
  } ftg_work_t;

endpackage

`default_nettype wire

>>> rtl/fft_twiddle_generator.sv
// fft_twiddle_generator: top level with configuration registers and the series pipeline.
// Depends on ftg_pkg, ftg_front, ftg_series_step and ftg_out.
//
//   channel  signals                          carries
//   index    index_valid / index_ready        index (11 bit twiddle index)
//   result   result_valid / result_ready      cos_value, sin_value (q1.15)
//   config   cfg_write, cfg_addr, cfg_data    log2_size (0), inverse (1)
//
// one item per cycle unless the result is stalled; four front stages, three per taylor term
// (seven terms: product, reciprocal multiply, correction and accumulate), one output stage.
// every stage has its own valid bit and empty stages fill while the result is stalled.
// synchronous reset clears the valid bits and loads log2_size = 10, inverse = 0.
`default_nettype none

module fft_twiddle_generator
  import ftg_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   index_valid,
  output logic                        index_ready,
  input  wire logic [INDEX_W-1:0]     index,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic signed [COEF_W-1:0]    cos_value,
  output logic signed [COEF_W-1:0]    sin_value
);

  logic [LOG2_W-1:0] log2_size;
  logic              inverse;

  ftg_work_t         work_chain [N_TERMS+1];
  logic [N_TERMS:0]  valid_chain;
  logic [N_TERMS:0]  ready_chain;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size <= LOG2_SIZE_RESET;
      inverse   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_addr)
        CFG_LOG2_SIZE: log2_size <= cfg_data[LOG2_W-1:0];
        CFG_INVERSE:   inverse   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ftg_front #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .log2_size(log2_size),
    .in_valid (index_valid),
    .in_ready (index_ready),
    .in_index (index),
    .out_valid(valid_chain[0]),
    .out_ready(ready_chain[0]),
    .out_work (work_chain[0])
  );

  for (genvar k = 0; k < N_TERMS; k++) begin : g_term
    ftg_series_step #(
      .K(k + 1)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_chain[k]),
      .in_ready (ready_chain[k]),
      .in_work  (work_chain[k]),
      .out_valid(valid_chain[k+1]),
      .out_ready(ready_chain[k+1]),
      .out_work (work_chain[k+1])
    );
  end

  ftg_out u_out (
    .clk      (clk),
    .rst      (rst),
    .inverse  (inverse),
    .in_valid (valid_chain[N_TERMS]),
    .in_ready (ready_chain[N_TERMS]),
    .in_work  (work_chain[N_TERMS]),
    .out_valid(result_valid),
    .out_ready(result_ready),
    .cos_value(cos_value),
    .sin_value(sin_value)
  );

endmodule

`default_nettype wire

>>> rtl/ftg_front.sv
// ftg_front: input register, phase fold into the first octant, angle and its square.
// Depends on ftg_pkg.
`default_nettype none

module ftg_front
  import ftg_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [LOG2_W-1:0]  log2_size,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [INDEX_W-1:0] in_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ftg_work_t               out_work
);

  logic               vld0, vld1, vld2, vld3;
  logic               en0, en1, en2, en3;
  logic [INDEX_W-1:0] index_r;
  logic [13:0]        fold;
  logic               swap1, swap2;
  logic [1:0]         quad1, quad2;
  logic [29:0]        theta;
  ftg_work_t          work;

  logic [4:0]  size_log2;
  logic [15:0] idx_mask;
  logic [15:0] phase;
  logic [13:0] octant_in;
  logic        swap_c;
  logic [45:0] theta_prod;
  logic [59:0] theta_sq;

  assign en3 = !vld3 || out_ready;
  assign en2 = !vld2 || en3;
  assign en1 = !vld1 || en2;
  assign en0 = !vld0 || en1;
  assign in_ready = en0;

  always_comb begin
    if (log2_size == '0) begin
      size_log2 = 5'd1;
    end else if (5'(log2_size) > 5'(MAX_LOG2_SIZE)) begin
      size_log2 = 5'(MAX_LOG2_SIZE);
    end else begin
      size_log2 = 5'(log2_size);
    end
  end

  // phase in 1/65536 of a turn, folded around the octant boundary
  assign idx_mask = 16'((17'd1 << (size_log2 - 5'd1)) - 17'd1);
  assign phase = (16'(index_r) & idx_mask) << (5'd16 - size_log2);
  assign octant_in = phase[13:0];
  assign swap_c = octant_in > 14'd8192;

  assign theta_prod = 46'(fold) * 46'(PI_Q30) + 46'd16384;
  assign theta_sq = 60'(theta) * 60'(theta);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (en0) vld0 <= in_valid;
      if (en1) vld1 <= vld0;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      index_r <= in_index;
    end
    if (en1) begin
      fold  <= swap_c ? 14'(15'd16384 - 15'(octant_in)) : octant_in;
      swap1 <= swap_c;
      quad1 <= phase[15:14];
    end
    if (en2) begin
      theta <= 30'(theta_prod >> 15);
      swap2 <= swap1;
      quad2 <= quad1;
    end
    if (en3) begin
      work.x2       <= 30'(theta_sq >> 30);
      work.sin_term <= 31'(theta);
      work.sin_sum  <= 31'(theta);
      work.cos_term <= ONE_Q30;
      work.cos_sum  <= ONE_Q30;
      work.swap     <= swap2;
      work.quad     <= quad2;
    end
  end

  assign out_valid = vld3;
  assign out_work = work;

endmodule

`default_nettype wire

>>> rtl/ftg_series_step.sv
// ftg_series_step: one taylor term of the sine and cosine series, in three stages.
// Depends on ftg_pkg; chained N_TERMS times in the top level.
`default_nettype none

module ftg_series_step
  import ftg_pkg::*;
#(
  parameter int K = 1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ftg_work_t in_work,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ftg_work_t      out_work
);

  localparam int SinDiv = (2 * K) * (2 * K + 1);
  localparam int CosDiv = (2 * K - 1) * (2 * K);
  // floor(2^31 / d): quotient estimate is low by at most one
  localparam logic [30:0] SinRecip = 31'((64'd1 << 31) / SinDiv);
  localparam logic [30:0] CosRecip = 31'((64'd1 << 31) / CosDiv);
  localparam logic [29:0] SinDivW = 30'(SinDiv);
  localparam logic [29:0] CosDivW = 30'(CosDiv);
  localparam bit Subtract = (K % 2) == 1;

  logic        vld_a, vld_b, vld_c;
  logic        en_a, en_b, en_c;
  ftg_work_t   work_a, work_b, work_c;
  logic [29:0] prod_s_a, prod_c_a;
  logic [29:0] prod_s_b, prod_c_b;
  logic [29:0] quo_s_b, quo_c_b;

  logic [60:0] mul_s, mul_c;
  logic [60:0] rcp_s, rcp_c;
  logic [29:0] rem_s, rem_c;
  logic [29:0] term_s, term_c;
  ftg_work_t   work_next;

  assign en_c = !vld_c || out_ready;
  assign en_b = !vld_b || en_c;
  assign en_a = !vld_a || en_b;
  assign in_ready = en_a;

  assign mul_s = 61'(in_work.sin_term) * 61'(in_work.x2);
  assign mul_c = 61'(in_work.cos_term) * 61'(in_work.x2);

  assign rcp_s = 61'(prod_s_a) * 61'(SinRecip);
  assign rcp_c = 61'(prod_c_a) * 61'(CosRecip);

  assign rem_s = prod_s_b - quo_s_b * SinDivW;
  assign rem_c = prod_c_b - quo_c_b * CosDivW;
  assign term_s = (rem_s >= SinDivW) ? quo_s_b + 30'd1 : quo_s_b;
  assign term_c = (rem_c >= CosDivW) ? quo_c_b + 30'd1 : quo_c_b;

  always_comb begin
    work_next = work_b;
    work_next.sin_term = 31'(term_s);
    work_next.cos_term = 31'(term_c);
    if (Subtract) begin
      work_next.sin_sum = work_b.sin_sum - 31'(term_s);
      work_next.cos_sum = work_b.cos_sum - 31'(term_c);
    end else begin
      work_next.sin_sum = work_b.sin_sum + 31'(term_s);
      work_next.cos_sum = work_b.cos_sum + 31'(term_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      if (en_a) vld_a <= in_valid;
      if (en_b) vld_b <= vld_a;
      if (en_c) vld_c <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      work_a   <= in_work;
      prod_s_a <= 30'(mul_s >> 30);
      prod_c_a <= 30'(mul_c >> 30);
    end
    if (en_b) begin
      work_b   <= work_a;
      prod_s_b <= prod_s_a;
      prod_c_b <= prod_c_a;
      quo_s_b  <= 30'(rcp_s >> 31);
      quo_c_b  <= 30'(rcp_c >> 31);
    end
    if (en_c) begin
      work_c <= work_next;
    end
  end

  assign out_valid = vld_c;
  assign out_work = work_c;

endmodule

`default_nettype wire

>>> rtl/ftg_out.sv
// ftg_out: rounding to q1.15, octant and quadrant mapping, result register.
// Depends on ftg_pkg.
`default_nettype none

module ftg_out
  import ftg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             inverse,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ftg_work_t        in_work,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic signed [COEF_W-1:0] cos_value,
  output logic signed [COEF_W-1:0] sin_value
);

  logic        en;
  logic [30:0] s0, c0;
  logic [15:0] s0_mag, c0_mag;
  logic [15:0] cos_mag, sin_mag;
  logic        cos_neg, sin_neg;

  function automatic logic [COEF_W-1:0] apply_sign(input logic [15:0] mag, input logic neg);
    logic [COEF_W-1:0] res;
    if (neg) begin
      res = COEF_W'(-mag);
    end else if (mag > 16'd32767) begin
      res = 16'h7FFF;
    end else begin
      res = COEF_W'(mag);
    end
    return res;
  endfunction

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  assign s0 = in_work.swap ? in_work.cos_sum : in_work.sin_sum;
  assign c0 = in_work.swap ? in_work.sin_sum : in_work.cos_sum;

  // magnitudes stay within 2^30, so the rounded value is at most 32768
  assign s0_mag = 16'((32'(s0) + 32'd16384) >> 15);
  assign c0_mag = 16'((32'(c0) + 32'd16384) >> 15);

  always_comb begin
    case (in_work.quad)
      QUAD_FIRST: begin
        cos_mag = c0_mag; cos_neg = 1'b0;
        sin_mag = s0_mag; sin_neg = 1'b0;
      end
      QUAD_SECOND: begin
        cos_mag = s0_mag; cos_neg = 1'b1;
        sin_mag = c0_mag; sin_neg = 1'b0;
      end
      QUAD_THIRD: begin
        cos_mag = c0_mag; cos_neg = 1'b1;
        sin_mag = s0_mag; sin_neg = 1'b1;
      end
      default: begin
        cos_mag = s0_mag; cos_neg = 1'b0;
        sin_mag = c0_mag; sin_neg = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_value <= apply_sign(cos_mag, cos_neg);
      sin_value <= apply_sign(sin_mag, sin_neg ^ inverse);
    end
  end

endmodule

`default_nettype wire
